>>> hdl/obl_pkg.sv
// ----------------------------------------------------------------------------
// obl_pkg: shared types and constants for the octree block lookup
// Walk states, configuration register indexes, input kind codes and octree word width.
// ----------------------------------------------------------------------------
`default_nettype none

package obl_pkg;

	localparam int unsigned WORD_W = 32;

	// register index = paddr[3:2]
	localparam logic [1:0] REG_WIDTH_SHIFT = 2'd0;
	localparam logic [1:0] REG_ZY_LAYOUT   = 2'd1;
	localparam logic [1:0] REG_Y_LAYOUT    = 2'd2;

	// input kind codes (tuser)
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROOT = 3'b010,
		ST_EVAL = 3'b100
	} walk_state_t;

	// layout shift amount: negative reads as zero
	function automatic logic [4:0] layout_amount(input logic signed [5:0] s);
		return s[5] ? 5'd0 : s[4:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/octree_block_lookup_top.sv
// ----------------------------------------------------------------------------
// octree_block_lookup_top: point lookup in a collision octree
// Loads octree words into a local memory and walks the tree for a query
// point, one node word per cycle, returning the leaf list offset.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Width  Contents
// s_*       in   144+1  tdata: word_address, word_data, pos_x, pos_y, pos_z
//                       tuser: kind (0 write word, 1 lookup)
// m_*       out  40+1   tdata: leaf_offset, final_shift; tuser: walk_error
// APB       in   32     width_shift @0x0, zy_layout_shift @0x4, y_layout_shift @0x8
//
// A write transaction stores its word at the accept edge.
// A lookup reads N node words (root included): one memory read per octree
// level, set by the single read port.
// The next transaction is taken the cycle after the walk finishes.
// The walk holds at its final step while the result register is still occupied.
// Reset clears control and configuration only; octree words are undefined
// until written, so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module octree_block_lookup_top #(
	parameter int unsigned OCTREE_WORDS = 4096
) (
	input  wire          clk,
	input  wire          arst_n,

	// APB configuration
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [3:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,

	// input stream
	input  wire          s_tvalid,
	output logic         s_tready,
	// [11:0] word_address, [43:12] word_data, [75:44] pos_x,
	// [107:76] pos_y, [139:108] pos_z, [143:140] zero
	input  wire  [143:0] s_tdata,
	// [0] kind
	input  wire  [0:0]   s_tuser,

	// result stream
	output logic         m_tvalid,
	input  wire          m_tready,
	// [31:0] leaf_offset, [36:32] final_shift, [39:37] zero
	output logic [39:0]  m_tdata,
	// [0] walk_error
	output logic [0:0]   m_tuser
);

	localparam int unsigned AW = $clog2(OCTREE_WORDS);
	localparam logic [33:0] MEM_BYTES = 34'(OCTREE_WORDS * 4);
	localparam logic [31:0] MEM_WORDS = 32'(OCTREE_WORDS);

	// ---------------- configuration registers ----------------
	logic [4:0]        width_shift_q;
	logic signed [5:0] zy_layout_q;
	logic signed [5:0] y_layout_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_shift_q <= 5'd0;
			zy_layout_q   <= -6'sd1;
			y_layout_q    <= -6'sd1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				obl_pkg::REG_WIDTH_SHIFT: width_shift_q <= pwdata[4:0];
				obl_pkg::REG_ZY_LAYOUT:   zy_layout_q   <= pwdata[5:0];
				obl_pkg::REG_Y_LAYOUT:    y_layout_q    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			obl_pkg::REG_WIDTH_SHIFT: prdata = {27'd0, width_shift_q};
			obl_pkg::REG_ZY_LAYOUT:   prdata = {{26{zy_layout_q[5]}}, zy_layout_q};
			obl_pkg::REG_Y_LAYOUT:    prdata = {{26{y_layout_q[5]}}, y_layout_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// ---------------- input unpacking ----------------
	logic        in_kind;
	logic [11:0] in_addr;
	logic [31:0] in_data, in_x, in_y, in_z;
	logic        s_acc;

	assign in_kind = s_tuser[0];
	assign in_addr = s_tdata[11:0];
	assign in_data = s_tdata[43:12];
	assign in_x    = s_tdata[75:44];
	assign in_y    = s_tdata[107:76];
	assign in_z    = s_tdata[139:108];
	assign s_acc   = s_tvalid & s_tready;

	// root cell index from coarse coordinates; wraps at 32 bits
	logic        single_root;
	logic [31:0] root_idx;

	assign single_root = (zy_layout_q == -6'sd1) && (y_layout_q == -6'sd1);

	always_comb begin
		if (single_root) begin
			root_idx = 32'd0;
		end else begin
			root_idx = (in_x >> width_shift_q)
			         | ((in_z >> width_shift_q) << obl_pkg::layout_amount(zy_layout_q))
			         | ((in_y >> width_shift_q) << obl_pkg::layout_amount(y_layout_q));
		end
	end

	// ---------------- walk state ----------------
	obl_pkg::walk_state_t state_q;
	logic [31:0] x_q, y_q, z_q;
	logic [4:0]  shift_q;
	logic [33:0] addr_q;     // byte address of the root node read
	logic [32:0] base_q;     // node base, byte offset

	logic [obl_pkg::WORD_W-1:0] rd_word;
	logic        rd_en;
	logic [AW-1:0] rd_idx;

	logic        out_free;
	logic [4:0]  shift_dn;
	logic [2:0]  child;
	logic [32:0] base_next;
	logic [33:0] next_addr;
	logic        next_oob;
	logic        root_oob;
	logic [31:0] leaf_val;

	assign out_free  = !m_tvalid || m_tready;
	assign shift_dn  = shift_q - 5'd1;
	assign child     = {z_q[shift_dn], y_q[shift_dn], x_q[shift_dn]};
	assign base_next = base_q + 33'(rd_word[30:0]);
	assign next_addr = 34'(base_next) + 34'({child, 2'b00});
	assign next_oob  = next_addr >= MEM_BYTES;
	assign root_oob  = addr_q >= MEM_BYTES;
	assign leaf_val  = base_q[31:0] + {1'b0, rd_word[30:0]};

	// result load and memory read decisions
	logic        fin;
	logic        fin_err;

	always_comb begin
		fin     = 1'b0;
		fin_err = 1'b0;
		rd_en   = 1'b0;
		rd_idx  = addr_q[AW+1:2];
		unique case (state_q)
			obl_pkg::ST_ROOT: begin
				if (root_oob) begin
					fin     = out_free;
					fin_err = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			obl_pkg::ST_EVAL: begin
				priority if (rd_word[31]) begin
					fin = out_free;
				end else if (shift_q == 5'd0 || next_oob) begin
					fin     = out_free;
					fin_err = 1'b1;
				end else begin
					rd_en  = 1'b1;
					rd_idx = next_addr[AW+1:2];
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == obl_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obl_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				obl_pkg::ST_IDLE: begin
					if (s_acc && in_kind == obl_pkg::KIND_LOOKUP) begin
						state_q <= obl_pkg::ST_ROOT;
					end
				end
				obl_pkg::ST_ROOT: begin
					if (rd_en) begin
						state_q <= obl_pkg::ST_EVAL;
					end else if (fin) begin
						state_q <= obl_pkg::ST_IDLE;
					end
				end
				obl_pkg::ST_EVAL: begin
					if (fin) begin
						state_q <= obl_pkg::ST_IDLE;
					end
				end
				default: state_q <= obl_pkg::ST_IDLE;
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			x_q     <= in_x;
			y_q     <= in_y;
			z_q     <= in_z;
			shift_q <= width_shift_q;
			addr_q  <= {root_idx, 2'b00};
			base_q  <= 33'd0;
		end else if (state_q == obl_pkg::ST_EVAL && rd_en) begin
			shift_q <= shift_dn;
			base_q  <= base_next;
		end
	end

	// ---------------- octree memory ----------------
	logic mem_wr;

	assign mem_wr = s_acc && (in_kind == obl_pkg::KIND_WRITE)
	              && (32'(in_addr) < MEM_WORDS);

	obl_mem #(
		.DEPTH(OCTREE_WORDS)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr),
		.wr_idx (AW'(in_addr)),
		.wr_data(in_data),
		.rd_en  (rd_en),
		.rd_idx (rd_idx),
		.rd_data(rd_word)
	);

	// ---------------- result register ----------------
	logic [31:0] leaf_q;
	logic [4:0]  fshift_q;
	logic        err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (fin) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			leaf_q   <= fin_err ? 32'd0 : leaf_val;
			fshift_q <= fin_err ? 5'd0 : shift_q;
			err_q    <= fin_err;
		end
	end

	assign m_tdata = {3'd0, fshift_q, leaf_q};
	assign m_tuser = err_q;

	// ---------------- assertions ----------------
	// every memory read stays inside the octree
	a_read_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (34'(rd_idx) << 2) < MEM_BYTES)
		else $error("octree read beyond memory");

	// each level descent lowers the shift by exactly one
	a_shift_descends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == obl_pkg::ST_EVAL && rd_en) |=> shift_q == $past(shift_q) - 5'd1)
		else $error("shift did not drop by one on descent");

	// node base stays inside memory while a word is evaluated
	a_base_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == obl_pkg::ST_EVAL |-> 34'(base_q) < MEM_BYTES)
		else $error("node base outside memory");

	// an error result carries zero offset and shift
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tdata == 40'd0)
		else $error("error result with nonzero payload");

	// a result is only produced by a lookup in progress
	a_fin_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (state_q == obl_pkg::ST_ROOT || state_q == obl_pkg::ST_EVAL))
		else $error("result loaded outside a walk");

endmodule

`default_nettype wire

>>> hdl/obl_mem.sv
// ----------------------------------------------------------------------------
// obl_mem: octree word store
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module obl_mem #(
	parameter int unsigned DEPTH = 4096
) (
	input  wire                           clk,
	input  wire                           wr_en,
	input  wire  [$clog2(DEPTH)-1:0]      wr_idx,
	input  wire  [obl_pkg::WORD_W-1:0]    wr_data,
	input  wire                           rd_en,
	input  wire  [$clog2(DEPTH)-1:0]      rd_idx,
	output logic [obl_pkg::WORD_W-1:0]    rd_data
);

	logic [obl_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// data stays put until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for octree_block_lookup_top
// Loads octree words over the input stream and runs point lookups under several
// root layouts. Each leaf result is checked against an in-bench walk of a
// mirrored word memory. A lookup is sent only once every word it reads is loaded.
// ----------------------------------------------------------------------------

localparam int unsigned OCT_WORDS = 4096;
localparam longint unsigned OCT_BYTES = 64'd4 * OCT_WORDS;

typedef struct packed {
	logic [31:0] leaf_offset;
	logic [4:0]  final_shift;
	logic        walk_error;
} leaf_result_t;

// mirror of the octree memory and registers; predicts and checks leaf results
class octree_mirror;
	logic [31:0]       words [OCT_WORDS];
	bit                loaded [OCT_WORDS];
	logic [4:0]        width_shift = 5'd0;
	logic signed [5:0] zy_layout = -6'sd1;
	logic signed [5:0] y_layout = -6'sd1;
	leaf_result_t      leaf_due [$];
	int unsigned       mismatches = 0;

	function void set_reg(logic [1:0] idx, logic [31:0] value);
		case (idx)
			obl_pkg::REG_WIDTH_SHIFT: width_shift = value[4:0];
			obl_pkg::REG_ZY_LAYOUT:   zy_layout = value[5:0];
			obl_pkg::REG_Y_LAYOUT:    y_layout = value[5:0];
			default: ;
		endcase
	endfunction

	// walks from the root cell; returns 1 (with index and base) if a word
	// that was never loaded would be read, else 0 with the leaf result
	function bit trace_walk(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, output leaf_result_t res,
			output int unsigned gap_idx, output longint unsigned gap_base);
		logic [31:0] root;
		logic [31:0] word;
		logic [4:0] zy_amt;
		logic [4:0] y_amt;
		logic [4:0] shift;
		longint unsigned base;
		longint unsigned addr;
		int unsigned idx;
		res = '{leaf_offset: 32'd0, final_shift: 5'd0, walk_error: 1'b1};
		gap_idx = 0;
		gap_base = 0;
		zy_amt = (zy_layout < 0) ? 5'd0 : zy_layout[4:0];
		y_amt = (y_layout < 0) ? 5'd0 : y_layout[4:0];
		if (zy_layout == -6'sd1 && y_layout == -6'sd1)
			root = 32'd0;
		else
			root = (x >> width_shift) | ((z >> width_shift) << zy_amt)
				| ((y >> width_shift) << y_amt);
		shift = width_shift;
		base = 0;
		addr = {32'd0, root} << 2;
		for (int lvl = 0; lvl <= 33; lvl++) begin
			if (addr >= OCT_BYTES)
				return 1'b0;
			idx = 32'(addr >> 2);
			if (!loaded[idx]) begin
				gap_idx = idx;
				gap_base = base;
				return 1'b1;
			end
			word = words[idx];
			if (word[31]) begin
				res.leaf_offset = 32'(base + {33'd0, word[30:0]});
				res.final_shift = shift;
				res.walk_error = 1'b0;
				return 1'b0;
			end
			base += {32'd0, word};
			if (shift == 5'd0)
				return 1'b0;
			shift--;
			addr = base + ({61'd0, z[shift], y[shift], x[shift]} << 2);
		end
		return 1'b0;
	endfunction

	function void note_item(logic kind, logic [11:0] waddr, logic [31:0] wdata,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		leaf_result_t res;
		int unsigned gi;
		longint unsigned gb;
		if (kind == obl_pkg::KIND_WRITE) begin
			words[waddr] = wdata;
			loaded[waddr] = 1'b1;
		end else begin
			void'(trace_walk(x, y, z, res, gi, gb));
			leaf_due.push_back(res);
		end
	endfunction

	function void check_leaf(leaf_result_t got);
		leaf_result_t want;
		if (leaf_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected leaf result: offset=%h shift=%0d err=%0b",
					got.leaf_offset, got.final_shift, got.walk_error);
			return;
		end
		want = leaf_due.pop_front();
		if (got.leaf_offset !== want.leaf_offset || got.final_shift !== want.final_shift
				|| got.walk_error !== want.walk_error) begin
			mismatches++;
			if (mismatches <= 10)
				$display("leaf mismatch: expected offset=%h shift=%0d err=%0b, got offset=%h shift=%0d err=%0b",
					want.leaf_offset, want.final_shift, want.walk_error,
					got.leaf_offset, got.final_shift, got.walk_error);
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 40;	// margin for the longest walk
	localparam int unsigned PHASES = 10;
	localparam int unsigned PHASE_ITEMS = 65;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [143:0] s_tdata = '0;	// addr, data, x, y, z from bit 0 up
	logic [0:0]  s_tuser = '0;	// kind

	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [39:0] m_tdata;	// leaf_offset, final_shift
	wire  [0:0]  m_tuser;	// walk_error

	octree_block_lookup_top #(.OCTREE_WORDS(OCT_WORDS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	octree_mirror mirror = new();

	bit          calm = 1'b0;	// no idling on either side once set
	int unsigned items_sent = 0;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;

	// root layouts walked in order: typical, lone negative y, extremes,
	// lone negative zy, single root, deep block, z pushed past bit 31
	int phase_ws [7] = '{3, 0, 31, 5, 1, 12, 0};
	int phase_zy [7] = '{4, 0, 31, -1, -1, 10, 31};
	int phase_y  [7] = '{2, -1, 31, 6, -1, 5, -1};

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("octree_block_lookup_top verification failed");
			$finish;
		end
	end

	// result side backpressure: random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Sample at the falling edge: values are settled and a transaction seen
	// here completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.check_leaf({m_tdata[31:0], m_tdata[36:32], m_tuser[0]});
	end

	// one input transaction, with an optional idle burst ahead of it;
	// called and returns at a rising edge
	task automatic push_item(logic kind, logic [11:0] waddr, logic [31:0] wdata,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		bit rdy;
		int unsigned gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'd0, z, y, x, wdata, waddr};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		mirror.note_item(kind, waddr, wdata, x, y, z);
		items_sent++;
	endtask

	// APB write: setup phase, then access until pready, then idle
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		bit rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mirror.set_reg(idx, value);
		@(posedge clk);
	endtask

	// stop input, let every lookup come back, then allow a trailing walk
	task automatic drain();
		s_tvalid <= 1'b0;
		while (mirror.leaf_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(int ws, int zy, int ys);
		drain();
		write_reg(obl_pkg::REG_WIDTH_SHIFT, 32'(ws));
		write_reg(obl_pkg::REG_ZY_LAYOUT, 32'(zy));
		write_reg(obl_pkg::REG_Y_LAYOUT, 32'(ys));
	endtask

	// Lookup that never reads an unloaded word: every gap on its path is
	// loaded first, mostly with leaves and in-range child offsets, so the
	// memory grows into random trees.
	task automatic lookup(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		leaf_result_t res;
		int unsigned gi;
		longint unsigned gb;
		longint unsigned room;
		int unsigned pick;
		logic [31:0] w;
		bit gap;
		gap = mirror.trace_walk(x, y, z, res, gi, gb);
		while (gap) begin
			pick = $urandom_range(0, 99);
			room = (gb < OCT_BYTES - 32) ? OCT_BYTES - 32 - gb : 0;
			if (pick < 40) begin
				w = {1'b1, 31'($urandom)};
			end else if (pick < 92) begin
				w = 32'($urandom_range(0, 32'(room)));
				if (pick < 84)
					w[1:0] = 2'b00;	// mostly aligned children
			end else begin
				w = $urandom;
			end
			push_item(obl_pkg::KIND_WRITE, 12'(gi), w, $urandom, $urandom, $urandom);
			gap = mirror.trace_walk(x, y, z, res, gi, gb);
		end
		push_item(obl_pkg::KIND_LOOKUP, 12'($urandom), $urandom, x, y, z);
	endtask

	// coordinate whose coarse part is 0..3, so the root stays near index 0
	function automatic logic [31:0] coarse_point(logic [4:0] ws);
		logic [63:0] c;
		logic [63:0] fine_mask;
		c = 64'($urandom_range(0, 3));
		fine_mask = (64'd1 << ws) - 1;
		return 32'((c << ws) | ({32'd0, $urandom} & fine_mask));
	endfunction

	initial begin
		int unsigned pick;
		int unsigned goal;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset layout is a single root at shift 0 ---
		push_item(obl_pkg::KIND_WRITE, 12'd0, 32'hFFFF_FFFF, '0, '0, '0);
		lookup('0, '0, '0);			// leaf at root, all offset bits set
		push_item(obl_pkg::KIND_WRITE, 12'd0, 32'h0000_0000, '1, '1, '1);
		lookup('1, '1, '1);			// node word at shift 0: underflow

		// one level of children under the single root
		apply_setting(2, -1, -1);
		push_item(obl_pkg::KIND_WRITE, 12'd0, 32'd32, '0, '0, '0);
		for (int k = 0; k < 8; k++)
			push_item(obl_pkg::KIND_WRITE, 12'(8 + k), 32'h8000_0000 | (k << 24) | k,
				'0, '0, '0);
		lookup(32'd2, '0, '0);			// x bit picks child 1
		lookup('1, '1, '1);			// child 7
		push_item(obl_pkg::KIND_WRITE, 12'd0, 32'd33, '0, '0, '0);
		lookup('0, 32'd2, '0);			// unaligned base, word index rounds down
		push_item(obl_pkg::KIND_WRITE, 12'd15, 32'd0, '0, '0, '0);
		push_item(obl_pkg::KIND_WRITE, 12'd0, 32'd32, '0, '0, '0);
		lookup('1, '1, '1);			// second node level runs out of shift
		push_item(obl_pkg::KIND_WRITE, 12'd0, 32'h7FFF_FFF0, '0, '0, '0);
		lookup(32'd1, '0, '0);			// child address past end of memory

		// lone negative y layout; root index just past memory
		apply_setting(0, 12, -1);
		lookup('0, '0, 32'd1);
		// coarse z shifted by 31: upper bits drop out of the root index
		apply_setting(0, 31, -1);
		lookup('0, '0, 32'd2);
		lookup('1, '0, '1);

		// --- random phases ---
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 7)
				apply_setting(phase_ws[ph], phase_zy[ph], phase_y[ph]);
			else
				apply_setting($urandom_range(0, 31), int'($urandom_range(0, 32)) - 1,
					int'($urandom_range(0, 32)) - 1);
			if (ph == PHASES - 1)
				calm <= 1'b1;
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					lookup(coarse_point(mirror.width_shift), coarse_point(mirror.width_shift),
						coarse_point(mirror.width_shift));
				else if (pick < 82)
					lookup($urandom, $urandom, $urandom);
				else
					push_item(obl_pkg::KIND_WRITE, 12'($urandom), $urandom, $urandom,
						$urandom, $urandom);
			end
		end

		drain();
		if (mirror.mismatches == 0 && mirror.leaf_due.size() == 0) begin
			$display("octree_block_lookup_top verification clean");
		end else begin
			$display("octree_block_lookup_top verification failed");
		end
		$finish;
	end

endmodule
